FILE: rtl/swstat_pkg.sv
// Shared types and constants for the sliding window statistics core.
// No dependencies; used by the front end, queue, back end and top level.
package swstat_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int UOUT_BITS   = SAMPLE_BITS - 1;
    localparam int WIN_BITS    = 6;
    localparam int FILL_BITS   = 7;
    localparam int SUM_BITS    = 32;
    localparam int SQ_BITS     = 56;
    localparam int TDATA_BITS  = 120;
    localparam int TUSER_BITS  = 3;

    localparam logic [WIN_BITS-1:0]  WIN_RESET = 6'd7;
    localparam logic [FILL_BITS-1:0] FILL_MAX  = 7'd127;
    // percent scale: 100 in Q7.8
    localparam logic [14:0]          PCT_SCALE = 15'd25600;
    localparam logic [UOUT_BITS-1:0] UOUT_MAX  = '1;

    // one classified sample handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic signed [SAMPLE_BITS-1:0] older;
        logic [WIN_BITS-1:0]           n;
        logic signed [SUM_BITS-1:0]    sum;
        logic [SQ_BITS-1:0]            sq;
        logic                          avg_ok;
        logic                          pct_ok;
        logic                          stats_ok;
    } t_job;

    // saturate a signed value to the sample range
    function automatic logic [SAMPLE_BITS-1:0] sat_s(input logic signed [40:0] x);
        logic signed [40:0] hi;
        logic signed [40:0] lo;
        hi = 41'sd8388607;
        lo = -41'sd8388608;
        if (x > hi) begin
            sat_s = 24'h7fffff;
        end else if (x < lo) begin
            sat_s = 24'h800000;
        end else begin
            sat_s = x[SAMPLE_BITS-1:0];
        end
    endfunction

endpackage

FILE: rtl/swstat_front.sv
// Front end: accepts samples, keeps the sample ring and the running sums,
// and hands one classified job per sample to the queue. Uses swstat_pkg.
module swstat_front #(
    parameter int RING_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_valid,
    output logic                                o_s_ready,
    input  logic signed [swstat_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                i_cfg_valid,
    input  logic [swstat_pkg::WIN_BITS-1:0]     i_cfg_data,
    input  logic                                i_full,
    output logic                                o_push,
    output swstat_pkg::t_job                    o_job
);
    localparam int AW   = $clog2(RING_DEPTH);
    localparam int NMAX = (RING_DEPTH - 1 < 63) ? RING_DEPTH - 1 : 63;
    localparam int SB   = swstat_pkg::SAMPLE_BITS;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_RD   = 4'b0010,
        F_UPD  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;
    logic [AW-1:0]                       r_wp;
    logic [swstat_pkg::FILL_BITS-1:0]    r_fill;
    logic signed [swstat_pkg::SUM_BITS-1:0] r_sum;
    logic [swstat_pkg::SQ_BITS-1:0]      r_sq;
    logic [swstat_pkg::WIN_BITS-1:0]     r_win;
    logic signed [SB-1:0]                r_s;
    logic signed [SB-1:0]                r_rd;
    logic signed [SB-1:0]                r_older;
    logic [2*SB-1:0]                     r_s2;
    logic [2*SB-1:0]                     r_l2;
    logic                                r_drop;
    logic [swstat_pkg::WIN_BITS-1:0]     r_n;
    logic [SB-1:0]                       r_mem [RING_DEPTH];

    logic                                w_acc;
    logic [swstat_pkg::WIN_BITS-1:0]     w_n;
    logic [9:0]                          w_os;
    logic [9:0]                          w_old;
    logic [SB-1:0]                       w_abs_in;
    logic [SB-1:0]                       w_abs_rd;

    // effective window: zero acts as one, clamp below ring depth
    always_comb begin
        w_n = r_win;
        if (w_n == '0) begin
            w_n = 6'd1;
        end
        if (w_n > 6'(NMAX)) begin
            w_n = 6'(NMAX);
        end
    end

    // slot one window back, modulo ring depth
    assign w_os  = 10'(r_wp) + 10'(RING_DEPTH) - 10'(w_n);
    assign w_old = (w_os >= 10'(RING_DEPTH)) ? w_os - 10'(RING_DEPTH) : w_os;

    assign o_s_ready = (r_state == F_IDLE);
    assign w_acc     = i_s_valid && o_s_ready;
    assign w_abs_in  = i_sample[SB-1] ? SB'(-i_sample) : i_sample;
    assign w_abs_rd  = r_rd[SB-1] ? SB'(-r_rd) : r_rd;

    // ring: write the new sample, read the leaving one
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mem[r_wp] <= i_sample;
            r_rd        <= r_mem[w_old[AW-1:0]];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (w_acc) n_state = F_RD;
            F_RD:   n_state = F_UPD;
            F_UPD:  n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // datapath: captured sample, window and drop flag, squares
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s    <= i_sample;
            r_s2   <= w_abs_in * w_abs_in;
            r_n    <= w_n;
            r_drop <= (r_fill >= 7'(w_n));
        end
        if (r_state == F_RD) begin
            r_older <= r_rd;
            r_l2    <= w_abs_rd * w_abs_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_win   <= swstat_pkg::WIN_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == F_RD) begin
                r_sum <= r_sum + 32'(r_s) - (r_drop ? 32'(r_rd) : 32'sd0);
            end
            if (r_state == F_UPD) begin
                r_sq <= r_sq + 56'(r_s2) - (r_drop ? 56'(r_l2) : 56'd0);
                if (r_fill != swstat_pkg::FILL_MAX) begin
                    r_fill <= r_fill + 7'd1;
                end
                r_wp <= (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            // window write restarts filling
            if (i_cfg_valid) begin
                r_win  <= i_cfg_data;
                r_fill <= '0;
                r_sum  <= '0;
                r_sq   <= '0;
            end
        end
    end

    assign o_push          = (r_state == F_PUSH) && !i_full;
    assign o_job.sample    = r_s;
    assign o_job.older     = r_older;
    assign o_job.n         = r_n;
    assign o_job.sum       = r_sum;
    assign o_job.sq        = r_sq;
    assign o_job.avg_ok    = r_fill > 7'(r_n);
    assign o_job.pct_ok    = (r_fill > 7'(r_n)) && (r_older != '0);
    assign o_job.stats_ok  = r_fill >= 7'(r_n);

endmodule

FILE: rtl/swstat_queue.sv
// Two-entry job queue between front and back end.
// Uses swstat_pkg::t_job.
module swstat_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  swstat_pkg::t_job  i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output swstat_pkg::t_job  o_job
);
    swstat_pkg::t_job r_q [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

FILE: rtl/swstat_back.sv
// Back end: one shared bit-serial divider and square root unit that turns
// a job into the result beat, plus the output register. Uses swstat_pkg.
module swstat_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_empty,
    input  swstat_pkg::t_job                       i_job,
    output logic                                   o_pop,
    output logic                                   o_m_valid,
    input  logic                                   i_m_ready,
    output logic [swstat_pkg::TDATA_BITS-1:0]      o_tdata,
    output logic [swstat_pkg::TUSER_BITS-1:0]      o_tuser
);
    typedef enum logic [7:0] {
        B_IDLE = 8'b0000_0001,
        B_MUL  = 8'b0000_0010,
        B_AVG  = 8'b0000_0100,
        B_PCT  = 8'b0000_1000,
        B_MEAN = 8'b0001_0000,
        B_VAR  = 8'b0010_0000,
        B_SQRT = 8'b0100_0000,
        B_DONE = 8'b1000_0000
    } t_bstate;

    t_bstate            r_state;
    swstat_pkg::t_job   r_job;
    logic [39:0]        r_pp;
    logic [61:0]        r_nq;
    logic [63:0]        r_ss;
    logic [11:0]        r_nn;
    // shared divider
    logic [63:0]        r_dvd;
    logic [23:0]        r_dvs;
    logic [23:0]        r_rem;
    logic [63:0]        r_quo;
    logic [6:0]         r_cnt;
    // square root
    logic [63:0]        r_v;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    // partial results
    logic [24:0]        r_qavg;
    logic [39:0]        r_qpct;
    logic [31:0]        r_qmean;
    logic               r_mnz;
    // output register
    logic               r_ov;
    logic [swstat_pkg::TDATA_BITS-1:0] r_tdata;
    logic [swstat_pkg::TUSER_BITS-1:0] r_tuser;

    logic signed [24:0] w_diff;
    logic [24:0]        w_adiff;
    logic [23:0]        w_aold;
    logic [31:0]        w_asum;
    logic [63:0]        w_num;
    logic [24:0]        w_rt;
    logic               w_ge;
    logic [24:0]        w_rn;
    logic [63:0]        w_qn;
    logic               w_last;
    logic [63:0]        w_st;
    logic               w_sge;
    logic               w_take;
    // result assembly
    logic [22:0]        w_avg;
    logic signed [40:0] w_pct_v;
    logic [23:0]        w_pct;
    logic [22:0]        w_sd;
    logic signed [26:0] w_mean;
    logic [23:0]        w_bu;
    logic [23:0]        w_bl;

    assign w_diff  = 25'(r_job.sample) - 25'(r_job.older);
    assign w_adiff = w_diff[24] ? 25'(-w_diff) : w_diff;
    assign w_aold  = r_job.older[23] ? 24'(-r_job.older) : r_job.older;
    assign w_asum  = r_job.sum[31] ? 32'(-r_job.sum) : r_job.sum;
    assign w_num   = (64'(r_nq) >= r_ss) ? 64'(r_nq) - r_ss : 64'd0;

    // restoring divide step, one quotient bit
    assign w_rt   = {r_rem, r_dvd[63]};
    assign w_ge   = w_rt >= {1'b0, r_dvs};
    assign w_rn   = w_ge ? w_rt - {1'b0, r_dvs} : w_rt;
    assign w_qn   = {r_quo[62:0], w_ge};
    assign w_last = (r_cnt == 7'd1);

    // square root step, two radicand bits
    assign w_st  = r_res + r_bit;
    assign w_sge = r_v >= w_st;

    assign o_pop  = (r_state == B_IDLE) && !i_empty;
    assign w_take = (r_state == B_DONE) && (!r_ov || i_m_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            case (r_state)
                B_IDLE: if (!i_empty) r_state <= B_MUL;
                B_MUL:  r_state <= B_AVG;
                B_AVG:  if (w_last) r_state <= B_PCT;
                B_PCT:  if (w_last) r_state <= B_MEAN;
                B_MEAN: if (w_last) r_state <= B_VAR;
                B_VAR:  if (w_last) r_state <= B_SQRT;
                B_SQRT: if (w_last) r_state <= B_DONE;
                B_DONE: if (w_take) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // datapath sequencing
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job <= i_job;
            end
            B_MUL: begin
                r_pp  <= 40'(w_adiff * swstat_pkg::PCT_SCALE);
                r_nq  <= r_job.n * r_job.sq;
                r_ss  <= w_asum * w_asum;
                r_nn  <= r_job.n * r_job.n;
                r_dvd <= {w_adiff, 39'd0};
                r_dvs <= 24'(r_job.n);
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= 7'd25;
            end
            B_AVG, B_PCT, B_MEAN, B_VAR: begin
                r_dvd <= {r_dvd[62:0], 1'b0};
                r_rem <= w_rn[23:0];
                r_quo <= w_qn;
                r_cnt <= r_cnt - 7'd1;
                if (w_last) begin
                    r_rem <= '0;
                    r_quo <= '0;
                    case (r_state)
                        B_AVG: begin
                            r_qavg <= w_qn[24:0];
                            r_dvd  <= {r_pp, 24'd0};
                            r_dvs  <= w_aold;
                            r_cnt  <= 7'd40;
                        end
                        B_PCT: begin
                            r_qpct <= w_qn[39:0];
                            r_dvd  <= {w_asum, 32'd0};
                            r_dvs  <= 24'(r_job.n);
                            r_cnt  <= 7'd32;
                        end
                        B_MEAN: begin
                            r_qmean <= w_qn[31:0];
                            r_mnz   <= (w_rn != '0);
                            r_dvd   <= w_num;
                            r_dvs   <= 24'(r_nn);
                            r_cnt   <= 7'd64;
                        end
                        default: begin
                            r_v   <= w_qn;
                            r_res <= '0;
                            r_bit <= 64'h4000_0000_0000_0000;
                            r_cnt <= 7'd32;
                        end
                    endcase
                end
            end
            B_SQRT: begin
                if (w_sge) begin
                    r_v   <= r_v - w_st;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 7'd1;
            end
            default: begin
            end
        endcase
    end

    // saturation and final values
    always_comb begin
        w_avg = '0;
        if (!w_diff[24] && (w_diff != '0)) begin
            w_avg = (r_qavg > 25'(swstat_pkg::UOUT_MAX)) ? swstat_pkg::UOUT_MAX
                                                          : r_qavg[22:0];
        end
        w_pct_v = (w_diff[24] ^ r_job.older[23]) ? -$signed({1'b0, r_qpct})
                                                  : $signed({1'b0, r_qpct});
        w_pct   = swstat_pkg::sat_s(w_pct_v);
        w_sd    = (r_res > 64'(swstat_pkg::UOUT_MAX)) ? swstat_pkg::UOUT_MAX
                                                       : r_res[22:0];
        if (r_job.sum[31]) begin
            w_mean = -$signed(27'(r_qmean[25:0]) + 27'(r_mnz));
        end else begin
            w_mean = $signed(27'(r_qmean[25:0]));
        end
        w_bu = swstat_pkg::sat_s(41'(w_mean) + 41'({w_sd, 1'b0}));
        w_bl = swstat_pkg::sat_s(41'(w_mean) - 41'({w_sd, 1'b0}));
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_take) begin
            r_ov <= 1'b1;
        end else if (i_m_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_tdata <= {2'b00,
                        r_job.stats_ok ? w_bl : 24'd0,
                        r_job.stats_ok ? w_bu : 24'd0,
                        r_job.stats_ok ? w_sd : 23'd0,
                        r_job.pct_ok   ? w_pct : 24'd0,
                        r_job.avg_ok   ? w_avg : 23'd0};
            r_tuser <= {r_job.stats_ok, r_job.pct_ok, r_job.avg_ok};
        end
    end

    assign o_m_valid = r_ov;
    assign o_tdata   = r_tdata;
    assign o_tuser   = r_tuser;

endmodule

FILE: rtl/sliding_window_statistics_core.sv
// Top level of the sliding window statistics core.
// Instantiates swstat_front, swstat_queue and swstat_back; uses swstat_pkg.
//
//  channel   dir  handshake                   payload
//  s_axis    in   i_s_axis_tvalid/o_..tready  tdata: sample
//  m_axis    out  o_m_axis_tvalid/i_..tready  tdata: stats, tuser: valid flags
//  cfg       in   i_cfg_valid/o_cfg_ready     window_length
//
// The front end takes a new sample only once the last one has gone through
// ring write/read, two sum updates and hand-off, which waits on a full queue.
// The back end handles one sample at a time: a shared bit-serial divider forms
// 25, 40, 32 and 64 bit quotients, the square root runs 32 steps; this sets the rate.
// Reset is synchronous and active low; the ring is not cleared.
// A stalled output holds its beat while the next sample is already taken.
module sliding_window_statistics_core #(
    parameter int RING_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [23:0]  i_s_axis_tdata,   // [23:0] sample
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [22:0] avg_gain, [46:23] percent_change, [69:47] std_dev,
    // [93:70] band_upper, [117:94] band_lower, [119:118] zero
    output logic [119:0] o_m_axis_tdata,
    // [0] avg_gain_valid, [1] percent_change_valid, [2] stats_valid
    output logic [2:0]   o_m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [5:0]   i_cfg_data
);
    swstat_pkg::t_job w_fjob;
    swstat_pkg::t_job w_qjob;
    logic             w_push;
    logic             w_full;
    logic             w_pop;
    logic             w_empty;

    assign o_cfg_ready = 1'b1;

    swstat_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .o_s_ready   (o_s_axis_tready),
        .i_sample    ($signed(i_s_axis_tdata)),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_fjob)
    );

    swstat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_qjob)
    );

    swstat_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_empty),
        .i_job     (w_qjob),
        .o_pop     (w_pop),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tuser   (o_m_axis_tuser)
    );

endmodule

FILE: rtl/swstat_checker.sv
// Port-level checks for the sliding window statistics core, and the bind
// that attaches them. Depends only on the top level's ports.
module swstat_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [119:0] o_m_axis_tdata,
    input logic [2:0]   o_m_axis_tuser
);
    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output beat changed while stalled");

    // percent valid needs gain valid, gain valid needs stats valid
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (!o_m_axis_tuser[1] || o_m_axis_tuser[0]) &&
                            (!o_m_axis_tuser[0] || o_m_axis_tuser[2]))
        else $error("valid flags inconsistent");

    // statistics fields are zero before the window fills
    a_stats_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[2] |-> o_m_axis_tdata[117:47] == '0)
        else $error("statistics not zero while invalid");

    // no beat right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind sliding_window_statistics_core swstat_checker u_swstat_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
